// ===== src/ctcgd_pkg.sv =====
// Shared types and constants for the CTC greedy decoder.
// No dependencies; imported by every module of the block.
package ctcgd_pkg;

    localparam int NUM_CLASSES = 8192;
    localparam int MAX_STEPS   = 1024;

    localparam int PROB_W  = 16;
    localparam int CLASS_W = 13;
    localparam int SUM_W   = 26;
    localparam int COUNT_W = 11;

    localparam int CLASS_LIMIT_I = (NUM_CLASSES < 8192) ? NUM_CLASSES : 8192;
    localparam int COUNT_CAP_I   = (MAX_STEPS < 2047) ? MAX_STEPS : 2047;

    localparam logic [CLASS_W:0]    CLASS_LIMIT = (CLASS_W + 1)'(CLASS_LIMIT_I);
    localparam logic [COUNT_W-1:0]  COUNT_CAP   = COUNT_W'(COUNT_CAP_I);
    localparam logic [CLASS_W-1:0]  BLANK_INDEX = '0;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    typedef struct packed {
        logic               char_valid;
        logic [CLASS_W-1:0] char_index;
        logic               seq_done;
        logic [SUM_W-1:0]   score_sum;
        logic [COUNT_W-1:0] char_count;
    } step_rec_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_DIVIDE
    } back_state_t;

endpackage

// ===== src/ctcgd_front.sv =====
// Front part: per-step argmax, blank/repeat filter, score accumulation.
// Depends on ctcgd_pkg; pushes one record per result into ctcgd_queue.
module ctcgd_front
    import ctcgd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [PROB_W-1:0] prob,
    input  logic              end_of_step,
    input  logic              end_of_sequence,
    input  logic              queue_full,
    output logic              push,
    output step_rec_t         push_rec
);

    logic [CLASS_W-1:0] class_counter_reg, class_counter_next;
    logic               class_over_reg, class_over_next;
    logic [PROB_W-1:0]  best_prob_reg, best_prob_next;
    logic [CLASS_W-1:0] best_index_reg, best_index_next;
    logic [CLASS_W-1:0] prev_index_reg, prev_index_next;
    logic [SUM_W-1:0]   score_sum_reg, score_sum_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic               accept;
    logic               take;
    logic [PROB_W-1:0]  cur_prob;
    logic [CLASS_W-1:0] cur_index;
    logic               emit;
    logic               seq_end;
    logic [SUM_W-1:0]   sum_upd;
    logic [COUNT_W-1:0] count_upd;

    assign in_stall = queue_full;
    assign accept   = in_valid && !in_stall;
    assign seq_end  = end_of_step && end_of_sequence;

    always_comb
    begin
        take      = !class_over_reg && ((class_counter_reg == '0) || (prob > best_prob_reg));
        cur_prob  = take ? prob : best_prob_reg;
        cur_index = take ? class_counter_reg : best_index_reg;
        emit      = (cur_index != BLANK_INDEX) && (cur_index != prev_index_reg);
        sum_upd   = score_sum_reg;
        count_upd = count_reg;
        if (emit && (count_reg < COUNT_CAP))
        begin
            sum_upd   = score_sum_reg + SUM_W'(cur_prob);
            count_upd = count_reg + COUNT_W'(1);
        end
    end

    always_comb
    begin
        class_counter_next = class_counter_reg;
        class_over_next    = class_over_reg;
        best_prob_next     = cur_prob;
        best_index_next    = cur_index;
        prev_index_next    = prev_index_reg;
        score_sum_next     = score_sum_reg;
        count_next         = count_reg;
        if (!class_over_reg)
        begin
            if (({1'b0, class_counter_reg} + (CLASS_W + 1)'(1)) >= CLASS_LIMIT)
                class_over_next = 1'b1;
            else
                class_counter_next = class_counter_reg + CLASS_W'(1);
        end
        if (end_of_step)
        begin
            class_counter_next = '0;
            class_over_next    = 1'b0;
            best_prob_next     = '0;
            best_index_next    = '0;
            prev_index_next    = cur_index;
            score_sum_next     = sum_upd;
            count_next         = count_upd;
            if (seq_end)
            begin
                prev_index_next = BLANK_INDEX;
                score_sum_next  = '0;
                count_next      = '0;
            end
        end
    end

    always_comb
    begin
        push                = accept && end_of_step && (emit || end_of_sequence);
        push_rec.char_valid = emit;
        push_rec.char_index = emit ? cur_index : '0;
        push_rec.seq_done   = seq_end;
        push_rec.score_sum  = sum_upd;
        push_rec.char_count = count_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_counter_reg <= '0;
            class_over_reg    <= 1'b0;
            best_prob_reg     <= '0;
            best_index_reg    <= '0;
            prev_index_reg    <= '0;
            score_sum_reg     <= '0;
            count_reg         <= '0;
        end
        else if (accept)
        begin
            class_counter_reg <= class_counter_next;
            class_over_reg    <= class_over_next;
            best_prob_reg     <= best_prob_next;
            best_index_reg    <= best_index_next;
            prev_index_reg    <= prev_index_next;
            score_sum_reg     <= score_sum_next;
            count_reg         <= count_next;
        end
    end

endmodule

// ===== src/ctcgd_queue.sv =====
// Short request queue between front and back parts.
// Depends on ctcgd_pkg for the record type and depth.
module ctcgd_queue
    import ctcgd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  step_rec_t push_rec,
    output logic      full,
    input  logic      pop,
    output step_rec_t pop_rec,
    output logic      empty
);

    step_rec_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;

    assign full    = (fill_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign pop_rec = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + (QPTR_W + 1)'(1);
        else if (pop && !push)
            fill_next = fill_reg - (QPTR_W + 1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== src/ctcgd_back.sv =====
// Back part: bit-serial mean division and the registered result stage.
// Depends on ctcgd_pkg; pops records from ctcgd_queue.
module ctcgd_back
    import ctcgd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               queue_empty,
    input  step_rec_t          pop_rec,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               char_valid,
    output logic [CLASS_W-1:0] char_index,
    output logic               seq_done,
    output logic [PROB_W-1:0]  mean_score,
    output logic               seq_valid,
    output logic [COUNT_W-1:0] char_count
);

    back_state_t state_reg, state_next;

    step_rec_t            rec_reg;
    logic [SUM_W-1:0]     quot_reg;
    logic [COUNT_W:0]     rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic                 out_valid_reg;
    logic                 char_valid_reg;
    logic [CLASS_W-1:0]   char_index_reg;
    logic                 seq_done_reg;
    logic [PROB_W-1:0]    mean_score_reg;
    logic                 seq_valid_reg;
    logic [COUNT_W-1:0]   char_count_reg;

    logic                 out_free;
    logic                 needs_div;
    logic                 load_direct;
    logic                 div_load;
    logic                 div_step;
    logic                 div_last;
    logic                 out_take;
    logic [COUNT_W:0]     rem_shift;
    logic                 q_bit;
    logic [COUNT_W:0]     rem_step;
    logic [SUM_W-1:0]     quot_step;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign needs_div = pop_rec.seq_done && (pop_rec.char_count != '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BACK_IDLE:
            begin
                if (!queue_empty && out_free && needs_div)
                    state_next = BACK_DIVIDE;
            end
            BACK_DIVIDE:
            begin
                if (div_cnt_reg == DIV_LAST)
                    state_next = BACK_IDLE;
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop         = 1'b0;
        load_direct = 1'b0;
        div_load    = 1'b0;
        div_step    = 1'b0;
        div_last    = 1'b0;
        unique case (state_reg)
            BACK_IDLE:
            begin
                pop         = !queue_empty && out_free;
                load_direct = pop && !needs_div;
                div_load    = pop && needs_div;
            end
            BACK_DIVIDE:
            begin
                div_step = 1'b1;
                div_last = (div_cnt_reg == DIV_LAST);
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rem_shift = {rem_reg[COUNT_W-1:0], quot_reg[SUM_W-1]};
        q_bit     = (rem_shift >= {1'b0, rec_reg.char_count});
        rem_step  = q_bit ? rem_shift - {1'b0, rec_reg.char_count} : rem_shift;
        quot_step = {quot_reg[SUM_W-2:0], q_bit};
    end

    always_ff @(posedge clk)
    begin
        if (div_load)
        begin
            rec_reg     <= pop_rec;
            quot_reg    <= pop_rec.score_sum;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else if (div_step)
        begin
            quot_reg    <= quot_step;
            rem_reg     <= rem_step;
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_direct)
        begin
            char_valid_reg <= pop_rec.char_valid;
            char_index_reg <= pop_rec.char_index;
            seq_done_reg   <= pop_rec.seq_done;
            mean_score_reg <= '0;
            seq_valid_reg  <= 1'b0;
            char_count_reg <= '0;
        end
        else if (div_last)
        begin
            char_valid_reg <= rec_reg.char_valid;
            char_index_reg <= rec_reg.char_index;
            seq_done_reg   <= 1'b1;
            mean_score_reg <= quot_step[PROB_W-1:0];
            seq_valid_reg  <= 1'b1;
            char_count_reg <= rec_reg.char_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_direct || div_last)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign char_valid = char_valid_reg;
    assign char_index = char_index_reg;
    assign seq_done   = seq_done_reg;
    assign mean_score = mean_score_reg;
    assign seq_valid  = seq_valid_reg;
    assign char_count = char_count_reg;

endmodule

// ===== src/ctc_greedy_decoder_top.sv =====
// Top level of the CTC greedy decoder: front, request queue and back part.
// Depends on ctcgd_pkg, ctcgd_front, ctcgd_queue and ctcgd_back.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  prob, end_of_step, end_of_sequence
//   out      out_valid/out_stall  char_valid, char_index, seq_done,
//                                 mean_score, seq_valid, char_count
//
// The front takes one score per cycle while in_stall is low; a step result is pushed
// into the queue, and the back part moves it on to the output register when that is free.
// A sequence end with emitted characters is loaded and run through the 26-step serial
// divider, and the back part pops nothing meanwhile; the 4-entry queue absorbs the backlog.
// Reset clears all control state; in_stall rises only when the queue is full.
module ctc_greedy_decoder_top
    import ctcgd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [PROB_W-1:0]  prob,
    input  logic               end_of_step,
    input  logic               end_of_sequence,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               char_valid,
    output logic [CLASS_W-1:0] char_index,
    output logic               seq_done,
    output logic [PROB_W-1:0]  mean_score,
    output logic               seq_valid,
    output logic [COUNT_W-1:0] char_count
);

    logic      push;
    step_rec_t push_rec;
    logic      queue_full;
    logic      pop;
    step_rec_t pop_rec;
    logic      queue_empty;

    ctcgd_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .prob            (prob),
        .end_of_step     (end_of_step),
        .end_of_sequence (end_of_sequence),
        .queue_full      (queue_full),
        .push            (push),
        .push_rec        (push_rec)
    );

    ctcgd_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .full     (queue_full),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .empty    (queue_empty)
    );

    ctcgd_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .pop_rec     (pop_rec),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .char_valid  (char_valid),
        .char_index  (char_index),
        .seq_done    (seq_done),
        .mean_score  (mean_score),
        .seq_valid   (seq_valid),
        .char_count  (char_count)
    );

endmodule
